// ----- rtl/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

    // Field widths
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CP_W   = 31;
    localparam int unsigned IDX_W  = 10;
    localparam int unsigned REM_W  = 3;
    localparam int unsigned ST_W   = 2;
    localparam int unsigned CLO_W  = 4;

    // Result channel data: code point, then char index, padded to whole bytes
    localparam int unsigned M_DATA_W = ((CP_W + IDX_W + 7) / 8) * 8;

    // Reset value of the character limit
    localparam logic [IDX_W-1:0] MAX_CHARS_RESET = IDX_W'(32);

    // Result status codes
    localparam logic [ST_W-1:0] ST_CHAR     = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [ST_W-1:0] ST_TRUNC    = 2'd2;

    // Leading-one counts with a meaning of their own
    localparam logic [CLO_W-1:0] CLO_ASCII = 4'd0;
    localparam logic [CLO_W-1:0] CLO_CONT  = 4'd1;
    localparam logic [CLO_W-1:0] CLO_MAX   = 4'd6;

    // One input request as held in the input register
    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              first_byte;
        logic              last_byte;
    } item_t;

    // One decode result
    typedef struct packed {
        logic              valid;
        logic [CP_W-1:0]   code_point;
        logic [ST_W-1:0]   status;
        logic              end_of_buffer;
        logic [IDX_W-1:0]  char_index;
    } res_t;

    // Count of leading one bits of a byte (0 to 8)
    function automatic logic [CLO_W-1:0] count_leading_ones(input logic [BYTE_W-1:0] b);
        logic [CLO_W-1:0] n;
        casez (b)
            8'b0???????: n = 4'd0;
            8'b10??????: n = 4'd1;
            8'b110?????: n = 4'd2;
            8'b1110????: n = 4'd3;
            8'b11110???: n = 4'd4;
            8'b111110??: n = 4'd5;
            8'b1111110?: n = 4'd6;
            8'b11111110: n = 4'd7;
            default:     n = 4'd8;
        endcase
        return n;
    endfunction

    // Payload bits of a lead byte, below the length prefix
    function automatic logic [CP_W-1:0] lead_payload(input logic [BYTE_W-1:0] b,
                                                     input logic [CLO_W-1:0] ones);
        logic [CP_W-1:0] p;
        case (ones)
            4'd2:    p = CP_W'(b[4:0]);
            4'd3:    p = CP_W'(b[3:0]);
            4'd4:    p = CP_W'(b[2:0]);
            4'd5:    p = CP_W'(b[1:0]);
            4'd6:    p = CP_W'(b[0]);
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/utf8_to_utf32_decoder.sv -----
// Channel  | Dir | Signals                    | Contents
// ---------+-----+----------------------------+-----------------------------------------
// s_       | in  | tvalid tready tdata tuser  | tdata data_byte, tuser first_byte,
//          |     | tlast                      | tlast last_byte
// m_       | out | tvalid tready tdata tuser  | tdata code_point, char_index;
//          |     | tlast                      | tuser status, tlast end_of_buffer
// cfg_     | in  | valid ready data           | max_chars (10 bits)
//
// One byte per cycle while m_tready is high: input register, decode logic,
// result register.
// Bytes that give no result (lead of a multibyte sequence, ignored bytes)
// only take their slot in the input register.
// A stall on m_tready holds the result register and backs up to s_tready.
// Reset (aresetn low, synchronous) empties both registers and clears state.
`default_nettype none

module utf8_to_utf32_decoder
    import utf8d_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    // configuration
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_data,     // max_chars
    // input bytes
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,      // [7:0] data_byte
    input  wire logic                s_tuser,      // [0] first_byte
    input  wire logic                s_tlast,      // last_byte
    // results
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata,      // [30:0] code_point, [40:31] char_index
    output logic [ST_W-1:0]          m_tuser,      // [1:0] status
    output logic                     m_tlast       // end_of_buffer
);

    item_t s_item;
    item_t item;
    res_t  res;
    logic  fire;
    logic  slot_free;

    assign cfg_ready = 1'b1;

    assign s_item.data_byte  = s_tdata;
    assign s_item.first_byte = s_tuser;
    assign s_item.last_byte  = s_tlast;

    utf8d_in_stage u_in (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_item    (s_item),
        .slot_free (slot_free),
        .fire      (fire),
        .item      (item)
    );

    utf8d_decode u_dec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .fire      (fire),
        .item      (item),
        .res       (res)
    );

    utf8d_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .fire      (fire),
        .res       (res),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ----- rtl/utf8d_in_stage.sv -----
`default_nettype none

module utf8d_in_stage
    import utf8d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire item_t             s_item,
    input  wire logic              slot_free,
    output logic                   fire,
    output item_t                  item
);

    logic  in_valid_reg;
    logic  in_valid_next;
    item_t item_reg;

    // Held byte moves on when the result register can take its outcome
    assign fire     = in_valid_reg && slot_free;
    assign s_tready = !in_valid_reg || slot_free;
    assign item     = item_reg;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8d_decode.sv -----
`default_nettype none

module utf8d_decode
    import utf8d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_valid,
    input  wire logic [IDX_W-1:0]  cfg_data,
    input  wire logic              fire,
    input  wire item_t             item,
    output res_t                   res
);

    logic [IDX_W-1:0] max_chars_reg;
    logic [CP_W-1:0]  acc_reg,    acc_next;
    logic [REM_W-1:0] rem_reg,    rem_next;
    logic             halted_reg, halted_next;
    logic [IDX_W-1:0] chars_reg,  chars_next;

    // State as seen after a first-of-buffer flag clears it
    logic [CP_W-1:0]  acc_eff;
    logic [REM_W-1:0] rem_eff;
    logic             halted_eff;
    logic [IDX_W-1:0] chars_eff;
    logic [CLO_W-1:0] ones;
    logic [CP_W-1:0]  acc_sh;
    logic [REM_W-1:0] rem_dec;

    assign acc_eff    = item.first_byte ? '0   : acc_reg;
    assign rem_eff    = item.first_byte ? '0   : rem_reg;
    assign halted_eff = item.first_byte ? 1'b0 : halted_reg;
    assign chars_eff  = item.first_byte ? '0   : chars_reg;

    assign ones    = count_leading_ones(item.data_byte);
    assign acc_sh  = {acc_eff[CP_W-7:0], item.data_byte[5:0]};
    assign rem_dec = rem_eff - REM_W'(1);

    // Per-byte decode and state update
    always_comb begin
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        halted_next = halted_reg;
        chars_next  = chars_reg;

        res.valid         = 1'b0;
        res.code_point    = '0;
        res.status        = ST_CHAR;
        res.end_of_buffer = item.last_byte;
        res.char_index    = chars_eff;

        if (fire) begin
            acc_next    = acc_eff;
            rem_next    = rem_eff;
            halted_next = halted_eff;
            chars_next  = chars_eff;

            if (!halted_eff) begin
                if (rem_eff == '0) begin
                    // lead position; bytes past the limit are dropped
                    if (chars_eff < max_chars_reg) begin
                        if (ones == CLO_ASCII) begin
                            res.valid      = 1'b1;
                            res.code_point = CP_W'(item.data_byte);
                            chars_next     = chars_eff + IDX_W'(1);
                        end else if (ones == CLO_CONT || ones > CLO_MAX) begin
                            res.valid   = 1'b1;
                            res.status  = ST_BAD_LEAD;
                            halted_next = 1'b1;
                        end else begin
                            acc_next = lead_payload(item.data_byte, ones);
                            rem_next = ones[REM_W-1:0] - REM_W'(1);
                            if (item.last_byte) begin
                                res.valid  = 1'b1;
                                res.status = ST_TRUNC;
                            end
                        end
                    end
                end else begin
                    // continuation: low six bits, unchecked
                    if (rem_dec == '0) begin
                        res.valid      = 1'b1;
                        res.code_point = acc_sh;
                        chars_next     = chars_eff + IDX_W'(1);
                        acc_next       = '0;
                        rem_next       = '0;
                    end else begin
                        acc_next = acc_sh;
                        rem_next = rem_dec;
                        if (item.last_byte) begin
                            res.valid  = 1'b1;
                            res.status = ST_TRUNC;
                        end
                    end
                end
            end

            // final byte always ends the buffer
            if (item.last_byte) begin
                halted_next = 1'b1;
                rem_next    = '0;
                acc_next    = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_chars_reg <= MAX_CHARS_RESET;
            acc_reg       <= '0;
            rem_reg       <= '0;
            halted_reg    <= 1'b0;
            chars_reg     <= '0;
        end else begin
            if (cfg_valid) begin
                max_chars_reg <= cfg_data;
            end
            acc_reg    <= acc_next;
            rem_reg    <= rem_next;
            halted_reg <= halted_next;
            chars_reg  <= chars_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/utf8d_out_stage.sv -----
`default_nettype none

module utf8d_out_stage
    import utf8d_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              fire,
    input  wire res_t              res,
    output logic                   slot_free,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [M_DATA_W-1:0]    m_tdata,
    output logic [ST_W-1:0]        m_tuser,
    output logic                   m_tlast
);

    logic            m_valid_reg, m_valid_next;
    logic [CP_W-1:0] cp_reg;
    logic [ST_W-1:0] st_reg;
    logic            eob_reg;
    logic [IDX_W-1:0] idx_reg;

    // Free when empty or being drained this cycle
    assign slot_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = res.valid;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    // Result payload, no reset
    always_ff @(posedge aclk) begin
        if (fire && res.valid) begin
            cp_reg  <= res.code_point;
            st_reg  <= res.status;
            eob_reg <= res.end_of_buffer;
            idx_reg <= res.char_index;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - CP_W - IDX_W)'(0), idx_reg, cp_reg};
    assign m_tuser  = st_reg;
    assign m_tlast  = eob_reg;

endmodule

`default_nettype wire

// ----- rtl/utf8d_checker.sv -----
`default_nettype none

module utf8d_checker
    import utf8d_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic [ST_W-1:0]     m_tuser,
    input  wire logic                m_tlast
);

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Error results carry a zero code point
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ST_CHAR |-> m_tdata[CP_W-1:0] == '0)
        else $error("error result with non-zero code point");

    // Only defined status codes appear
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == ST_CHAR || m_tuser == ST_BAD_LEAD || m_tuser == ST_TRUNC))
        else $error("undefined status code");

    // Truncation is only reported on the final byte
    a_trunc_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ST_TRUNC |-> m_tlast)
        else $error("truncation without end of buffer");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind utf8_to_utf32_decoder utf8d_checker u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ----- tb/sv/utf8_decode_checker.sv -----
`timescale 1ns / 100ps

// Watches the request, result and limit channels of the UTF-8 decoder,
// predicts every result from the accepted requests and compares in order.
module utf8_decode_checker
    import utf8d_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_valid,
    input  wire logic                cfg_ready,
    input  wire logic [IDX_W-1:0]    cfg_data,
    input  wire logic                s_tvalid,
    input  wire logic                s_tready,
    input  wire logic [BYTE_W-1:0]   s_tdata,
    input  wire logic                s_tuser,
    input  wire logic                s_tlast,
    input  wire logic                m_tvalid,
    input  wire logic                m_tready,
    input  wire logic [M_DATA_W-1:0] m_tdata,
    input  wire logic [ST_W-1:0]     m_tuser,
    input  wire logic                m_tlast,
    output int                       fail_count,
    output int                       pending_count
);

    localparam int REPORT_CAP = 100;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [ST_W-1:0]  status;
        logic             end_of_buffer;
        logic [IDX_W-1:0] char_index;
    } decoded_t;

    // Predicted decoder state
    logic [IDX_W-1:0] char_limit = MAX_CHARS_RESET;
    logic [CP_W-1:0]  partial    = '0;
    logic [REM_W-1:0] cont_left  = '0;
    logic             stopped    = 1'b0;
    logic [IDX_W-1:0] char_count = '0;

    decoded_t due_results[$];

    initial begin
        fail_count    = 0;
        pending_count = 0;
    end

    function automatic int unsigned prefix_ones(input logic [BYTE_W-1:0] b);
        int unsigned n;
        n = 0;
        while (n < BYTE_W && b[BYTE_W-1-n])
            n++;
        return n;
    endfunction

    function automatic decoded_t make_result(input logic [CP_W-1:0] cp,
                                             input logic [ST_W-1:0] st,
                                             input logic eob,
                                             input logic [IDX_W-1:0] idx);
        decoded_t r;
        r.code_point    = cp;
        r.status        = st;
        r.end_of_buffer = eob;
        r.char_index    = idx;
        return r;
    endfunction

    // Advance the predicted state by one request, queueing any result
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic first,
                               input logic last);
        int unsigned n;
        decoded_t    r;
        logic        give;
        give = 1'b0;
        if (first) begin
            stopped    = 1'b0;
            char_count = '0;
            cont_left  = '0;
            partial    = '0;
        end
        if (stopped)
            return;

        if (cont_left == 0) begin
            // lead position; nothing happens once the limit is reached
            if (char_count < char_limit) begin
                n = prefix_ones(b);
                if (n == 0) begin
                    r          = make_result(CP_W'(b), ST_CHAR, last, char_count);
                    give       = 1'b1;
                    char_count = char_count + 1'b1;
                end else if (n == 1 || n > 6) begin
                    r       = make_result('0, ST_BAD_LEAD, last, char_count);
                    give    = 1'b1;
                    stopped = 1'b1;
                end else begin
                    partial   = CP_W'(int'(b) & ((1 << (7 - n)) - 1));
                    cont_left = REM_W'(n - 1);
                    if (last) begin
                        r         = make_result('0, ST_TRUNC, last, char_count);
                        give      = 1'b1;
                        cont_left = '0;
                        partial   = '0;
                    end
                end
            end
        end else begin
            // any byte here counts as a continuation
            partial   = {partial[CP_W-7:0], b[5:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == 0) begin
                r          = make_result(partial, ST_CHAR, last, char_count);
                give       = 1'b1;
                char_count = char_count + 1'b1;
                partial    = '0;
            end else if (last) begin
                r         = make_result('0, ST_TRUNC, last, char_count);
                give      = 1'b1;
                cont_left = '0;
                partial   = '0;
            end
        end

        if (last) begin
            stopped   = 1'b1;
            cont_left = '0;
            partial   = '0;
        end
        if (give)
            due_results.push_back(r);
    endtask

    // Compare one delivered result against the oldest prediction
    task automatic check_result();
        decoded_t want;
        decoded_t got;
        logic     bad;
        got = make_result(m_tdata[CP_W-1:0], m_tuser, m_tlast,
                          m_tdata[CP_W+IDX_W-1:CP_W]);
        if (due_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_CAP)
                $display("%0t: unexpected result, expected none, got %h", $time, got);
            return;
        end
        want = due_results.pop_front();
        bad  = 1'b0;
        if (got.code_point !== want.code_point) begin
            bad = 1'b1;
            if (fail_count < REPORT_CAP)
                $display("%0t: code_point expected %h got %h", $time,
                         want.code_point, got.code_point);
        end
        if (got.status !== want.status) begin
            bad = 1'b1;
            if (fail_count < REPORT_CAP)
                $display("%0t: status expected %0d got %0d", $time,
                         want.status, got.status);
        end
        if (got.end_of_buffer !== want.end_of_buffer) begin
            bad = 1'b1;
            if (fail_count < REPORT_CAP)
                $display("%0t: end_of_buffer expected %b got %b", $time,
                         want.end_of_buffer, got.end_of_buffer);
        end
        if (got.char_index !== want.char_index) begin
            bad = 1'b1;
            if (fail_count < REPORT_CAP)
                $display("%0t: char_index expected %0d got %0d", $time,
                         want.char_index, got.char_index);
        end
        if (bad)
            fail_count++;
    endtask

    // Sample all three channels on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            char_limit = MAX_CHARS_RESET;
            partial    = '0;
            cont_left  = '0;
            stopped    = 1'b0;
            char_count = '0;
            due_results.delete();
        end else begin
            if (m_tvalid && m_tready)
                check_result();
            if (cfg_valid && cfg_ready)
                char_limit = cfg_data;
            if (s_tvalid && s_tready)
                decode_byte(s_tdata, s_tuser, s_tlast);
        end
        pending_count = due_results.size();
    end

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import utf8d_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [IDX_W-1:0]    cfg_data;
    logic                s_tvalid;
    logic                s_tready;
    logic [BYTE_W-1:0]   s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;
    logic [ST_W-1:0]     m_tuser;
    logic                m_tlast;

    int fail_count;
    int pending_count;
    int src_gap_pct   = 0;
    int dst_stall_pct = 0;
    int items_sent    = 0;
    int cycles        = 0;

    utf8_to_utf32_decoder u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    utf8_decode_checker u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always #5 aclk = ~aclk;

    // Result side back-pressure
    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= dst_stall_pct);
    end

    // Run-away guard
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Offer one request, with random gaps ahead of it, until it is taken
    task automatic push_byte(input logic [BYTE_W-1:0] b, input logic first,
                             input logic last);
        while ($urandom_range(99) < src_gap_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tuser  = first;
        s_tlast  = last;
        do
            @(posedge aclk);
        while (!s_tready);
        @(negedge aclk);
        s_tvalid = 1'b0;
        items_sent++;
    endtask

    // Hold off until every predicted result is out and the pipe has emptied
    task automatic wait_drained();
        while (pending_count != 0)
            @(negedge aclk);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [IDX_W-1:0] value);
        wait_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Lead byte of a sequence of the given length with a random payload
    function automatic logic [BYTE_W-1:0] lead_byte(input int unsigned len);
        return BYTE_W'((8'hFF << (8 - len)) | ($urandom & ((1 << (7 - len)) - 1)));
    endfunction

    // One buffer: mostly well-formed characters; unless clean, some noise,
    // bad leads, a truncated tail and stray first/last flags
    task automatic random_buffer(input int unsigned n_chars, input bit clean);
        logic [BYTE_W-1:0] seq[$];
        int unsigned       kind;
        int unsigned       len;
        int unsigned       k;
        int unsigned       i;
        logic              first;
        logic              last;
        for (k = 0; k < n_chars; k++) begin
            kind = $urandom_range(99);
            if (kind < (clean ? 88 : 45)) begin
                seq.push_back(BYTE_W'($urandom_range(127)));
            end else if (clean || kind < 85) begin
                len = $urandom_range(2, 6);
                seq.push_back(lead_byte(len));
                for (i = 1; i < len; i++)
                    seq.push_back(8'h80 | BYTE_W'($urandom_range(63)));
            end else if (kind < 93) begin
                seq.push_back(BYTE_W'($urandom_range(255)));
            end else if (kind < 97) begin
                seq.push_back(8'h80 | BYTE_W'($urandom_range(63)));
            end else begin
                seq.push_back(8'hFE | BYTE_W'($urandom_range(1)));
            end
        end
        if (!clean && $urandom_range(99) < 15) begin
            len = $urandom_range(2, 6);
            seq.push_back(lead_byte(len));
            k = $urandom_range(0, len - 2);
            for (i = 0; i < k; i++)
                seq.push_back(8'h80 | BYTE_W'($urandom_range(63)));
        end
        for (i = 0; i < seq.size(); i++) begin
            if (i == 0)
                first = ($urandom_range(99) < 94);
            else
                first = !clean && ($urandom_range(99) < 2);
            if (i == seq.size() - 1)
                last = ($urandom_range(99) < 94);
            else
                last = !clean && ($urandom_range(99) < 2);
            push_byte(seq[i], first, last);
        end
    endtask

    initial begin
        int                unsigned phase;
        int                unsigned phase_end;
        int                unsigned n_buf;
        int                unsigned span;
        logic [IDX_W-1:0]  limit;

        aresetn   = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        s_tlast   = 1'b0;
        m_tready  = 1'b0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed requests at the reset limit
        src_gap_pct   = 30;
        dst_stall_pct = 30;
        push_byte(8'h41, 1'b0, 1'b0);   // decoded before any first flag
        push_byte(8'h00, 1'b1, 1'b0);
        push_byte(8'h7F, 1'b0, 1'b0);
        push_byte(8'hC2, 1'b0, 1'b0);
        push_byte(8'hA9, 1'b0, 1'b0);
        push_byte(8'hFD, 1'b0, 1'b0);   // six bytes, largest code point
        repeat (5) push_byte(8'hBF, 1'b0, 1'b0);
        push_byte(8'hE2, 1'b0, 1'b0);
        push_byte(8'hC3, 1'b0, 1'b0);   // lead byte where continuation due
        push_byte(8'hAC, 1'b0, 1'b0);
        push_byte(8'h80, 1'b0, 1'b0);   // lone continuation as lead
        push_byte(8'h41, 1'b0, 1'b0);   // dropped while halted
        push_byte(8'hFE, 1'b1, 1'b0);
        push_byte(8'hFF, 1'b1, 1'b0);
        push_byte(8'hF0, 1'b1, 1'b0);
        push_byte(8'h9F, 1'b0, 1'b1);   // buffer ends mid-sequence
        push_byte(8'hF4, 1'b1, 1'b1);   // lead byte is also the final byte
        push_byte(8'h7F, 1'b1, 1'b1);

        // Random phases: limit setting and idling pattern per phase
        for (phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    src_gap_pct   = 14;
                    dst_stall_pct = 86;
                end
                1: begin
                    src_gap_pct   = 86;
                    dst_stall_pct = 14;
                end
                default: begin
                    src_gap_pct   = 0;
                    dst_stall_pct = 0;
                end
            endcase
            case (phase)
                0:       limit = IDX_W'(1);
                1:       limit = IDX_W'(1023);
                2:       limit = IDX_W'($urandom_range(2, 8));
                3:       limit = IDX_W'($urandom_range(1, 1023));
                4:       limit = IDX_W'(3);
                default: limit = MAX_CHARS_RESET;
            endcase
            write_limit(limit);
            // one long clean buffer to walk the character index up high
            if (phase == 1)
                random_buffer(520, 1'b1);
            span      = (limit + 3 < 14) ? limit + 3 : 14;
            phase_end = items_sent + 165;
            n_buf     = 0;
            while (items_sent < phase_end) begin
                random_buffer($urandom_range(1, span), 1'b0);
                n_buf++;
                if (n_buf % 25 == 0)
                    wait_drained();
            end
        end

        wait_drained();
        if (fail_count == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
